[rtl/assert_macros.svh]
// Assertion macros shared by the key table RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising edge of clk, skipped while rst is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check prop at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/lckt_pkg.sv]
// Shared types and constants for the lazy clear key table.
// No dependencies; imported by every module of the block.
package lckt_pkg;

   localparam int OP_W      = 3;
   localparam int KEY_W     = 16;
   localparam int VAL_W     = 31;
   localparam int CONTRIB_W = 32;
   localparam int TOTAL_W   = 64;
   localparam int PCOUNT_W  = 17;
   localparam int COUNT_W   = 32;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
   localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

   localparam logic [CONTRIB_W-1:0] CONTRIB_MISS = '1;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [CONTRIB_W-1:0] contribution;
      logic signed [TOTAL_W-1:0]   running_total;
      logic [PCOUNT_W-1:0]         present_count;
      logic                        stamp_overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic clr_wr;
      logic accept;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic out_free;
   } stat_type;

endpackage

[rtl/lazy_clear_key_table.sv]
// Keyed table with constant-time bulk clear. Each entry of a 2^KEY_BITS deep
// single-port-write RAM holds a live bit, a 31-bit value and the sequence
// stamp of its last write; a clear-all records the current stamp and every
// entry stamped at or before it reads as empty. Each word on req_ (insert,
// remove, clear all, add count, query) produces exactly one word on rsp_
// with its contribution, the 64-bit running total, the live count and a
// sticky stamp-wrap flag. Each item gets a registered RAM read of the
// addressed entry, then a commit that compares stamps, writes the entry
// back, updates the total and loads the result register; the commit waits
// while rsp_stall holds an earlier result, and the next word is taken in
// the cycle after the commit, never while one is in flight. A result
// waiting in the result register does not block acceptance of the next
// word. After reset the block sweeps the entry RAM to zero, one entry per
// cycle, with req_stall held high. Once the stamp counter wraps, presence
// tests may return stale answers; stamp_overflow flags it.
// Depends on lckt_pkg, lckt_ctrl and lckt_dpath.
module lazy_clear_key_table
   import lckt_pkg::*;
#(
   parameter int KEY_BITS   = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: clearing pass, accept, commit once the result register is free
   lckt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // entry RAM, stamp and count registers, running total, result register
   lckt_dpath #(
      .KEY_BITS   (KEY_BITS),
      .STAMP_BITS (STAMP_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

[rtl/lckt_ctrl.sv]
// Sequencer for the key table: clearing pass, item accept, commit.
// Depends on lckt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lckt_ctrl
   import lckt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   `ASSERT_RST(a_one_item, clock, reset, cmd.accept |=> req_stall && !cmd.accept, "second word taken while one is in flight")
   `ASSERT_RST(a_exec_frees, clock, reset, cmd.exec |=> !req_stall, "port not reopened after commit")
   `ASSERT_RST(a_no_mix, clock, reset, !(cmd.clr_wr && (cmd.accept || cmd.exec)), "item work during clearing pass")

endmodule

[rtl/lckt_dpath.sv]
// Datapath of the key table: entry RAM, stamps, count, total, result register.
// Depends on lckt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lckt_dpath
   import lckt_pkg::*;
#(
   parameter int KEY_BITS   = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   output stat_type stat,
   input  req_type  req_word,
   input  logic     rsp_stall,
   output logic     rsp_valid,
   output rsp_type  rsp_word
);

   localparam int DEPTH  = 1 << KEY_BITS;
   localparam int WORD_W = 1 + VAL_W + STAMP_BITS;
   localparam int LIVE_B = WORD_W - 1;

   // entry word: live bit, value, stamp of last write
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_ff;
   logic [WORD_W-1:0] wr_data;
   logic [KEY_BITS-1:0] wr_addr;
   logic              wr_en;

   logic [KEY_BITS-1:0]   clr_addr_ff;
   logic [OP_W-1:0]       op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VAL_W-1:0]      value_ff;

   logic [STAMP_BITS-1:0] seq_ff, seq_in;
   logic [STAMP_BITS-1:0] clr_stamp_ff, clr_stamp_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic                  wrap_ff, wrap_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [STAMP_BITS-1:0] rd_stamp;
   logic [VAL_W-1:0]      rd_value;
   logic                  rd_live;
   logic                  present;
   logic                  item_wr;
   logic [WORD_W-1:0]     item_data;
   logic [CONTRIB_W-1:0]  contrib;

   assign rd_stamp = rd_ff[STAMP_BITS-1:0];
   assign rd_value = rd_ff[STAMP_BITS+VAL_W-1:STAMP_BITS];
   assign rd_live  = rd_ff[LIVE_B];
   assign present  = (rd_stamp > clr_stamp_ff) && rd_live;

   // clearing sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_addr_ff <= clr_addr_ff + KEY_BITS'(1);
      end
   end

   assign stat.clr_last = (clr_addr_ff == '1);

   // capture the item
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_word.op;
         key_ff   <= KEY_BITS'(req_word.key);
         value_ff <= req_word.value;
      end
   end

   // read-modify-write of one entry
   always_comb begin
      seq_in       = seq_ff + STAMP_BITS'(1);
      wrap_in      = wrap_ff | (seq_in == '0);
      clr_stamp_in = clr_stamp_ff;
      count_in     = count_ff;
      contrib      = '0;
      item_wr      = 1'b0;
      item_data    = rd_ff;
      case (op_ff)
         OP_INSERT: begin
            item_wr   = 1'b1;
            item_data = {1'b1, value_ff, seq_in};
            if (!present) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (present) begin
               item_wr   = 1'b1;
               item_data = {1'b0, rd_value, seq_in};
               count_in  = count_ff - COUNT_W'(1);
            end
         end
         OP_CLEAR: begin
            clr_stamp_in = seq_in;
            count_in     = '0;
         end
         OP_COUNT: begin
            contrib = CONTRIB_W'(count_ff);
         end
         OP_QUERY: begin
            contrib = present ? {1'b0, rd_value} : CONTRIB_MISS;
         end
         default: begin
         end
      endcase
      total_in = total_ff + {{(TOTAL_W-CONTRIB_W){contrib[CONTRIB_W-1]}}, contrib};
   end

   assign wr_en   = cmd.clr_wr || (cmd.exec && item_wr);
   assign wr_addr = cmd.clr_wr ? clr_addr_ff : key_ff;
   assign wr_data = cmd.clr_wr ? '0 : item_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.accept) begin
         rd_ff <= mem[KEY_BITS'(req_word.key)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         clr_stamp_ff <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         wrap_ff      <= 1'b0;
      end else if (cmd.exec) begin
         seq_ff       <= seq_in;
         clr_stamp_ff <= clr_stamp_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         wrap_ff      <= wrap_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff.contribution   <= contrib;
         rsp_ff.running_total  <= total_in;
         rsp_ff.present_count  <= PCOUNT_W'(count_in);
         rsp_ff.stamp_overflow <= wrap_in;
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_ff;

   `ASSERT_RST(a_total_hold, clock, reset, (!$past(reset) && !$past(cmd.exec)) |-> $stable(total_ff), "total moved without a commit")
   `ASSERT_RST(a_count_bound, clock, reset, !wrap_ff |-> (count_ff <= COUNT_W'(DEPTH)), "count above table depth before stamp wrap")

endmodule
